### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the rtl, clocked on clk with reset rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define CHK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/rsbp_pkg.sv
// ----------------------------------------------------------------------------
// rsbp_pkg
// record layout and key compare for the price-keyed record sorter
// ----------------------------------------------------------------------------
package rsbp_pkg;

  localparam int PRICE_W = 31;
  localparam int ID_W    = 14;
  localparam int STOCK_W = 31;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [ID_W-1:0]    id;
    logic [STOCK_W-1:0] stock;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // price first, id breaks ties
  function automatic logic rec_le(rec_t x, rec_t y);
    return {x.price, x.id} <= {y.price, y.id};
  endfunction

endpackage

### src/rsbp_ram.sv
// ----------------------------------------------------------------------------
// rsbp_ram
// generic ram, one write port and two read ports, registered read data
// ----------------------------------------------------------------------------
module rsbp_ram #(
  parameter int WIDTH = 76,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

### src/record_sort_by_price_top.sv
// ----------------------------------------------------------------------------
// record_sort_by_price_top
// collects records, then emits them sorted by price, ties by ascending id
// ----------------------------------------------------------------------------
// Records are taken one per cycle while ready is high and stored in order; a
// record that arrives when RECORDS are already held is dropped. The transaction
// with last set starts a stable bottom-up merge sort over the n stored records,
// and ready stays low until the sorted run has been delivered. The sort runs on
// one compare unit between two ping-pong rams with two read ports each, over
// ceil(log2(n)) passes. Emission reads each record into an output register and
// holds it there until out_ready takes it. Records equal in price and id leave
// in load order; out_last marks the final one.
`include "assert_macros.svh"

module record_sort_by_price_top #(
  parameter int RECORDS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid,
  output logic                          ready,
  input  logic [rsbp_pkg::PRICE_W-1:0]  price,
  input  logic [rsbp_pkg::ID_W-1:0]     record_id,
  input  logic [rsbp_pkg::STOCK_W-1:0]  stock,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rsbp_pkg::PRICE_W-1:0]  out_price,
  output logic [rsbp_pkg::ID_W-1:0]     out_id,
  output logic [rsbp_pkg::STOCK_W-1:0]  out_stock,
  output logic                          out_last
);

  import rsbp_pkg::*;

  localparam int CW = $clog2(RECORDS + 1);
  localparam int AW = $clog2(RECORDS);
  localparam int SW = CW + 2;
  localparam logic [CW-1:0] CAP = CW'(RECORDS);

  typedef enum logic [2:0] {
    S_LOAD, S_SETUP, S_MERGE, S_EMIT_RD, S_EMIT_LD, S_EMIT_HOLD
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] n_rec;
  logic [CW-1:0] a;
  logic [CW-1:0] b;
  logic [CW-1:0] mid;
  logic [CW-1:0] hi;
  logic [CW-1:0] k;
  logic [CW-1:0] w;
  logic [CW-1:0] idx;
  logic          src;
  rec_t          out_rec;

  rec_t          in_rec;
  logic          accept_in;
  logic          store_ok;
  logic [CW-1:0] n_load;
  rec_t          rd_a0, rd_a1, rd_b0, rd_b1;
  rec_t          ra, rb, mrg_rec;
  logic          a_ok, b_ok, take_a;
  logic [CW-1:0] a_step, b_step, k_inc;
  logic          blk_end, pass_end, sort_done;
  logic [SW-1:0] nb_mid_s, nb_hi_s, w2_s, np_hi_s;
  logic [CW-1:0] nb_mid, nb_hi, np_mid, np_hi;
  logic [CW-1:0] rd_addr0, rd_addr1;
  logic          we_a, we_b;
  logic [AW-1:0] waddr_a;
  rec_t          wdata_a;

  assign in_rec    = '{price: price, id: record_id, stock: stock};
  assign ready     = (state == S_LOAD);
  assign accept_in = valid && ready;
  assign store_ok  = (count < CAP);
  assign n_load    = store_ok ? count + 1'b1 : count;

  assign ra = src ? rd_b0 : rd_a0;
  assign rb = src ? rd_b1 : rd_a1;

  // merge compare unit
  assign a_ok    = (a < mid);
  assign b_ok    = (b < hi);
  assign take_a  = a_ok && (!b_ok || rec_le(ra, rb));
  assign mrg_rec = take_a ? ra : rb;
  assign a_step  = a + CW'(take_a);
  assign b_step  = b + CW'(!take_a);
  assign k_inc   = k + 1'b1;
  assign blk_end  = (k_inc == hi);
  assign pass_end = blk_end && (hi == n_rec);

  // bounds of the next block and of the next pass
  assign nb_mid_s  = SW'(hi) + SW'(w);
  assign nb_hi_s   = SW'(hi) + (SW'(w) << 1);
  assign nb_mid    = (nb_mid_s < SW'(n_rec)) ? nb_mid_s[CW-1:0] : n_rec;
  assign nb_hi     = (nb_hi_s < SW'(n_rec)) ? nb_hi_s[CW-1:0] : n_rec;
  assign w2_s      = SW'(w) << 1;
  assign np_hi_s   = SW'(w) << 2;
  assign np_mid    = (w2_s < SW'(n_rec)) ? w2_s[CW-1:0] : n_rec;
  assign np_hi     = (np_hi_s < SW'(n_rec)) ? np_hi_s[CW-1:0] : n_rec;
  assign sort_done = (w2_s >= SW'(n_rec));

  always_comb begin
    case (state)
      S_SETUP: begin
        rd_addr0 = a;
        rd_addr1 = b;
      end
      S_MERGE: begin
        if (blk_end) begin
          rd_addr0 = hi;
          rd_addr1 = nb_mid;
        end else begin
          rd_addr0 = a_step;
          rd_addr1 = b_step;
        end
      end
      default: begin
        rd_addr0 = idx;
        rd_addr1 = idx;
      end
    endcase
  end

  // ram a takes the load and even pass results, ram b the odd ones
  assign we_a    = (accept_in && store_ok) || (state == S_MERGE && src);
  assign we_b    = (state == S_MERGE) && !src;
  assign waddr_a = (state == S_MERGE) ? k[AW-1:0] : count[AW-1:0];
  assign wdata_a = (state == S_MERGE) ? mrg_rec : in_rec;

  rsbp_ram #(.WIDTH(REC_W), .DEPTH(RECORDS)) u_ram_a (
    .clk    (clk),
    .we     (we_a),
    .waddr  (waddr_a),
    .wdata  (wdata_a),
    .raddr0 (rd_addr0[AW-1:0]),
    .raddr1 (rd_addr1[AW-1:0]),
    .rdata0 (rd_a0),
    .rdata1 (rd_a1)
  );

  rsbp_ram #(.WIDTH(REC_W), .DEPTH(RECORDS)) u_ram_b (
    .clk    (clk),
    .we     (we_b),
    .waddr  (k[AW-1:0]),
    .wdata  (mrg_rec),
    .raddr0 (rd_addr0[AW-1:0]),
    .raddr1 (rd_addr1[AW-1:0]),
    .rdata0 (rd_b0),
    .rdata1 (rd_b1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      src       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept_in) begin
            if (store_ok) begin
              count <= count + 1'b1;
            end
            if (last) begin
              n_rec <= n_load;
              src   <= 1'b0;
              w     <= CW'(1);
              a     <= '0;
              mid   <= CW'(1);
              b     <= CW'(1);
              hi    <= CW'(2);
              k     <= '0;
              idx   <= '0;
              state <= (n_load > CW'(1)) ? S_SETUP : S_EMIT_RD;
            end
          end
        end
        S_SETUP: begin
          state <= S_MERGE;
        end
        S_MERGE: begin
          if (pass_end) begin
            src <= !src;
            if (sort_done) begin
              idx   <= '0;
              state <= S_EMIT_RD;
            end else begin
              w     <= w2_s[CW-1:0];
              a     <= '0;
              mid   <= np_mid;
              b     <= np_mid;
              hi    <= np_hi;
              k     <= '0;
              state <= S_SETUP;
            end
          end else if (blk_end) begin
            k   <= k_inc;
            a   <= hi;
            mid <= nb_mid;
            b   <= nb_mid;
            hi  <= nb_hi;
          end else begin
            k <= k_inc;
            a <= a_step;
            b <= b_step;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          out_rec   <= ra;
          out_last  <= (idx == n_rec - 1'b1);
          out_valid <= 1'b1;
          idx       <= idx + 1'b1;
          state     <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              count <= '0;
              state <= S_LOAD;
            end else begin
              state <= S_EMIT_LD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign out_price = out_rec.price;
  assign out_id    = out_rec.id;
  assign out_stock = out_rec.stock;

  `CHK(a_count_cap, count <= CAP, "fill count above capacity")
  `CHK(a_ready_idle, ready |-> !out_valid, "input ready while a result is pending")
  `CHK(a_merge_ab, (state == S_MERGE) |-> (a <= mid && b <= hi && k < hi), "bad merge pointers")
  `CHK(a_merge_live, (state == S_MERGE) |-> (a_ok || b_ok), "merge with both runs empty")
  `CHK(a_run_end, out_valid && out_ready && out_last |=> ready && count == '0, "store not emptied")
  `CHK_RST(a_reset_out, rst |=> !out_valid, "result valid after reset")

endmodule
